@@ sv/tpp_pkg.sv @@
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and request codes for the timed on/off pattern player.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam logic [1:0] REQ_POLL  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [5:0]  table_index;
        logic        step_on;
        logic [15:0] step_duration;
        logic [6:0]  pattern_length;
    } t_in_item;

    typedef struct packed {
        logic       motor_on;
        logic       playing;
        logic [6:0] step_number;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming item
        logic exec;    // apply the captured item
    } t_dp_cmd;

endpackage

@@ sv/tpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpp_ctrl
// Controller: takes an item, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module tpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output tpp_pkg::t_dp_cmd o_cmd,
    output logic             o_done
);
    import tpp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state == S_EXEC);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_done     = r_done;

endmodule

@@ sv/tpp_dp.sv @@
// ----------------------------------------------------------------------------
// tpp_dp
// Datapath: step table, playback registers, deadline add and compare.
// ----------------------------------------------------------------------------
module tpp_dp #(
    parameter int TABLE_DEPTH   = 64,
    parameter int DURATION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpp_pkg::t_dp_cmd  i_cmd,
    input  tpp_pkg::t_in_item i_item,
    output tpp_pkg::t_out_item o_result
);
    import tpp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IDX_N = 64;    // codes of the 6-bit table_index field

    t_in_item r_item;

    // step table: {motor bit, duration}
    logic [DURATION_BITS:0] r_mem [TABLE_DEPTH];
    logic [DURATION_BITS:0] r_rd;

    // table address of the next step to load (step r_counter + 1)
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic [6:0]    r_steps;
    logic [6:0]    n_steps;
    logic [6:0]    r_counter;
    logic [6:0]    n_counter;
    logic [31:0]   r_deadline;
    logic [31:0]   n_deadline;
    logic          r_motor;
    logic          n_motor;
    logic          r_active;
    logic          n_active;
    t_out_item     r_result;

    // index modulo depth, constant table
    logic [AW-1:0] w_mod_tab [IDX_N];
    for (genvar g = 0; g < IDX_N; g++) begin : g_mod
        assign w_mod_tab[g] = AW'(g % TABLE_DEPTH);
    end

    logic [AW-1:0]          w_idx;
    logic [DURATION_BITS-1:0] w_wr_dur;
    logic [AW-1:0]          w_addr_inc;
    logic [31:0]            w_rd_dur;
    logic                   w_rd_on;
    logic                   w_expired;

    assign w_idx      = w_mod_tab[r_item.table_index];
    assign w_wr_dur   = DURATION_BITS'(r_item.step_duration);
    assign w_addr_inc = (r_addr == AW'(TABLE_DEPTH - 1)) ? '0 : r_addr + AW'(1);
    assign w_rd_dur   = 32'(r_rd[DURATION_BITS-1:0]);
    assign w_rd_on    = r_rd[DURATION_BITS];
    assign w_expired  = (r_item.now_ms >= r_deadline);

    always_comb begin
        n_addr     = r_addr;
        n_steps    = r_steps;
        n_counter  = r_counter;
        n_deadline = r_deadline;
        n_motor    = r_motor;
        n_active   = r_active;
        unique case (r_item.req_type)
            REQ_POLL: begin
                if (r_active) begin
                    if (r_counter == 7'd0) begin
                        n_deadline = r_item.now_ms + w_rd_dur;
                        n_motor    = w_rd_on;
                        n_counter  = 7'd1;
                        n_addr     = w_addr_inc;
                    end else if (w_expired) begin
                        if (r_counter >= r_steps) begin
                            n_motor  = 1'b0;
                            n_active = 1'b0;
                        end else begin
                            n_deadline = r_deadline + w_rd_dur;
                            n_motor    = w_rd_on;
                            n_counter  = r_counter + 7'd1;
                            n_addr     = w_addr_inc;
                        end
                    end
                end
            end
            REQ_START: begin
                n_addr    = w_idx;
                n_steps   = r_item.pattern_length;
                n_counter = 7'd0;
                if (r_item.pattern_length == 7'd0) begin
                    n_motor  = 1'b0;
                    n_active = 1'b0;
                end else begin
                    n_active = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result <= '{motor_on: n_motor, playing: n_active, step_number: n_counter};
        end
    end

    // table write and registered read; the read follows r_addr every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_item.req_type == REQ_WRITE) begin
            r_mem[w_idx] <= {r_item.step_on, w_wr_dur};
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= AW'(1);
            r_steps    <= 7'd0;
            r_counter  <= 7'd1;
            r_deadline <= 32'd0;
            r_motor    <= 1'b0;
            r_active   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_addr     <= n_addr;
            r_steps    <= n_steps;
            r_counter  <= n_counter;
            r_deadline <= n_deadline;
            r_motor    <= n_motor;
            r_active   <= n_active;
        end
    end

    assign o_result = r_result;

endmodule

@@ sv/timed_onoff_pattern_player.sv @@
// ----------------------------------------------------------------------------
// timed_onoff_pattern_player
// Plays an on/off motor pattern from a step table against polled ms time.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start / busy       i_item   (tpp_pkg::t_in_item)
//  result    o_done strobe      o_result (tpp_pkg::t_out_item)
//
//  Each item is accepted, then runs the execute state (busy high), and
//  the result strobes for one cycle while the next item may already be
//  accepted. The step table read is registered and follows the next-step
//  address, so data is ready by the execute state. Synchronous active-low
//  reset stops playback with the motor off (o_result is not reset); table
//  contents are undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module timed_onoff_pattern_player #(
    parameter int TABLE_DEPTH   = 64,
    parameter int DURATION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tpp_pkg::t_in_item  i_item,
    output logic               o_done,
    output tpp_pkg::t_out_item o_result
);
    import tpp_pkg::*;

    t_dp_cmd w_cmd;

    tpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .o_done  (o_done)
    );

    tpp_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
